// ===== rtl/cws_pkg.sv =====
// Shared types, constants and microcode encodings for the weighted sampler.
`timescale 1ns / 1ps
`default_nettype none

package cws_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SUM_WIDTH_DEF   = 48;
  localparam int CMD_W           = 1;
  localparam int WEIGHT_W        = 32;
  localparam int VALUE_W         = 48;
  localparam int ID_W            = 48;
  localparam int STEP_W          = 4;

  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_DRAW = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SINIT,
    OP_READ,
    OP_STEP,
    OP_FOUND,
    OP_LOAD,
    OP_UNIQ
  } cws_op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ACC,
    C_LOAD,
    C_UNIQ,
    C_SDONE
  } cws_cond_t;

  typedef struct packed {
    cws_op_t   op;
    cws_cond_t cond;
    step_t     target;
    logic      emit;
    logic      accept;
  } ctrl_word_t;

  typedef struct packed {
    cws_op_t op;
    logic    emit;
    logic    accept;
  } ctrl_t;

  typedef struct packed {
    logic accepted;
    logic is_load;
    logic is_uniq;
    logic sdone;
    logic out_busy;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/cws_if.sv =====
// Valid/ready channel interfaces for draw/load items and results.
`timescale 1ns / 1ps
`default_nettype none

interface cws_in_if import cws_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [WEIGHT_W-1:0] weight;
  logic [VALUE_W-1:0]  random_value;

  modport source (output valid, cmd, weight, random_value, input ready);
  modport sink   (input valid, cmd, weight, random_value, output ready);
endinterface

interface cws_out_if import cws_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] content_id;
  logic            is_unique;
  logic            status;

  modport source (output valid, content_id, is_unique, status, input ready);
  modport sink   (input valid, content_id, is_unique, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/cws_table.sv =====
// Prefix-sum memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cws_table
  import cws_pkg::*;
#(
  parameter int  DEPTH = TABLE_DEPTH_DEF,
  parameter int  WIDTH = SUM_WIDTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cws_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module cws_seq
  import cws_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire flags_t flags,
  output ctrl_t       ctrl
);

  localparam step_t ST_IDLE  = STEP_W'(0);
  localparam step_t ST_DISP  = STEP_W'(1);
  localparam step_t ST_CHKU  = STEP_W'(2);
  localparam step_t ST_SINIT = STEP_W'(3);
  localparam step_t ST_PROBE = STEP_W'(4);
  localparam step_t ST_CMP   = STEP_W'(5);
  localparam step_t ST_FOUND = STEP_W'(6);
  localparam step_t ST_LOAD  = STEP_W'(7);
  localparam step_t ST_UNIQ  = STEP_W'(8);

  function automatic ctrl_word_t prog_rom(input step_t s);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE, emit: 1'b0, accept: 1'b0};
    unique case (s)
      ST_IDLE:  w = '{op: OP_NOP,   cond: C_NO_ACC, target: ST_IDLE,  emit: 1'b0, accept: 1'b1};
      ST_DISP:  w = '{op: OP_NOP,   cond: C_LOAD,   target: ST_LOAD,  emit: 1'b0, accept: 1'b0};
      ST_CHKU:  w = '{op: OP_NOP,   cond: C_UNIQ,   target: ST_UNIQ,  emit: 1'b0, accept: 1'b0};
      ST_SINIT: w = '{op: OP_SINIT, cond: C_NEXT,   target: ST_IDLE,  emit: 1'b0, accept: 1'b0};
      ST_PROBE: w = '{op: OP_READ,  cond: C_SDONE,  target: ST_FOUND, emit: 1'b0, accept: 1'b0};
      ST_CMP:   w = '{op: OP_STEP,  cond: C_ALWAYS, target: ST_PROBE, emit: 1'b0, accept: 1'b0};
      ST_FOUND: w = '{op: OP_FOUND, cond: C_ALWAYS, target: ST_IDLE,  emit: 1'b1, accept: 1'b0};
      ST_LOAD:  w = '{op: OP_LOAD,  cond: C_ALWAYS, target: ST_IDLE,  emit: 1'b1, accept: 1'b0};
      ST_UNIQ:  w = '{op: OP_UNIQ,  cond: C_ALWAYS, target: ST_IDLE,  emit: 1'b1, accept: 1'b0};
      default:  w = '{op: OP_NOP,   cond: C_ALWAYS, target: ST_IDLE,  emit: 1'b0, accept: 1'b0};
    endcase
    return w;
  endfunction

  step_t      step_r;
  step_t      step_nxt;
  ctrl_word_t cw;
  logic       stall;
  logic       taken;

  assign cw    = prog_rom(step_r);
  assign stall = cw.emit && flags.out_busy;

  always_comb begin
    unique case (cw.cond)
      C_NEXT:   taken = 1'b0;
      C_ALWAYS: taken = 1'b1;
      C_NO_ACC: taken = !flags.accepted;
      C_LOAD:   taken = flags.is_load;
      C_UNIQ:   taken = flags.is_uniq;
      C_SDONE:  taken = flags.sdone;
      default:  taken = 1'b1;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  assign ctrl.op     = stall ? OP_NOP : cw.op;
  assign ctrl.emit   = cw.emit && !stall;
  assign ctrl.accept = cw.accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cumulative_weight_sampler_unit.sv =====
// Top level of the weighted sampler: datapath, prefix-sum table and sequencer.
// A searched draw takes P <= ceil(log2(entry_count + 1)) probes. One item at a time;
// the next input is accepted once the sequencer is back in idle, which it enters as
// the result is registered; a result not yet taken by the output holds the sequencer.
// Each probe has two steps: memory read, then compare and narrow.
// Synchronous active-low reset empties the table, sets the unique counter to one.
`timescale 1ns / 1ps
`default_nettype none

module cumulative_weight_sampler_unit
  import cws_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SUM_WIDTH   = SUM_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cws_in_if.sink    in_ch,
  cws_out_if.source out_ch
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (SUM_WIDTH > VALUE_W) ? SUM_WIDTH : VALUE_W;

  ctrl_t  ctrl;
  flags_t flags;
  logic   accepted;

  logic [CMD_W-1:0]     cmd_r;
  logic [WEIGHT_W-1:0]  weight_r;
  logic [VALUE_W-1:0]   value_r;
  logic [CNT_W-1:0]     count_r;
  logic [ID_W-1:0]      uniq_r;
  logic [SUM_WIDTH-1:0] last_sum_r;
  logic [CNT_W-1:0]     lo_r;
  logic [CNT_W-1:0]     hi_r;
  logic                 out_valid_r;
  logic [ID_W-1:0]      out_id_r;
  logic                 out_uniq_r;
  logic                 out_status_r;

  logic [CNT_W-1:0]     mid;
  logic [SUM_WIDTH-1:0] new_sum;
  logic [SUM_WIDTH-1:0] rd_sum;
  logic                 full;
  logic                 sdone;
  logic                 probe_gt;
  logic                 tbl_we;
  logic                 tbl_re;

  assign accepted = in_ch.valid && in_ch.ready;
  assign in_ch.ready = ctrl.accept;

  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign new_sum  = last_sum_r + SUM_WIDTH'(weight_r);
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign sdone    = (lo_r >= hi_r);
  assign probe_gt = (CMP_W'(rd_sum) > CMP_W'(value_r));
  assign tbl_we   = (ctrl.op == OP_LOAD) && !full;
  assign tbl_re   = (ctrl.op == OP_READ) && !sdone;

  assign flags.accepted = accepted;
  assign flags.is_load  = (cmd_r == CMD_LOAD);
  assign flags.is_uniq  = (count_r == '0) || (CMP_W'(value_r) >= CMP_W'(last_sum_r));
  assign flags.sdone    = sdone;
  assign flags.out_busy = out_valid_r && !out_ch.ready;

  cws_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  cws_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (SUM_WIDTH)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (count_r[IDX_W-1:0]),
    .wdata   (new_sum),
    .re      (tbl_re),
    .raddr   (mid[IDX_W-1:0]),
    .rdata_r (rd_sum)
  );

  always_ff @(posedge clk) begin
    if (accepted) begin
      cmd_r    <= in_ch.cmd;
      weight_r <= in_ch.weight;
      value_r  <= in_ch.random_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      uniq_r      <= ID_W'(1);
      last_sum_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctrl.op)
        OP_LOAD: begin
          if (!full) begin
            count_r    <= count_r + CNT_W'(1);
            uniq_r     <= ID_W'(count_r) + ID_W'(2);
            last_sum_r <= new_sum;
          end
        end
        OP_UNIQ: uniq_r <= uniq_r + ID_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_SINIT: begin
        lo_r <= '0;
        hi_r <= count_r;
      end
      OP_STEP: begin
        if (probe_gt) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid + CNT_W'(1);
        end
      end
      OP_FOUND: begin
        out_id_r     <= ID_W'(lo_r);
        out_uniq_r   <= 1'b0;
        out_status_r <= STATUS_OK;
      end
      OP_LOAD: begin
        out_id_r     <= '0;
        out_uniq_r   <= 1'b0;
        out_status_r <= full ? STATUS_FULL : STATUS_OK;
      end
      OP_UNIQ: begin
        out_id_r     <= uniq_r;
        out_uniq_r   <= 1'b1;
        out_status_r <= STATUS_OK;
      end
      default: ;
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.content_id = out_id_r;
  assign out_ch.is_unique  = out_uniq_r;
  assign out_ch.status     = out_status_r;

endmodule

`default_nettype wire
